// ----- rtl/mws_pkg.sv -----
// Shared constants and types for the minimum window subsequence unit.
package mws_pkg;

    localparam int MAX_TEXT    = 1024;
    localparam int MAX_PATTERN = 64;
    localparam int SYM_W       = 32;
    localparam int CNT_W       = 11;
    localparam int TEXT_AW     = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int PCNT_W      = $clog2(MAX_PATTERN + 1);

    typedef struct packed {
        logic wr;
        logic clear;
        logic step;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

// ----- rtl/min_window_subsequence_unit.sv -----
// Top level of the minimum window subsequence unit: load control, text RAM, cell chain, result.
//
// Text (mode 0) and pattern words (mode 1) are taken one per cycle in S_LOAD and stored, up to
// 1024 text and 64 pattern symbols; extras are dropped and flagged as overflow. A pattern word
// with last set starts the search: the text RAM is read back to front, one symbol per cycle,
// and each symbol is broadcast to a row of 64 pattern cells that each keep the shortest span
// matching the pattern from their position on, handing that span to the cell before them.
// The input stays closed during a search and until the result can enter the output register,
// which waits while an earlier result is still held there. The single result is held in an
// output register until taken, and the unit is empty again for the next problem.
module min_window_subsequence_unit
    import mws_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic signed [SYM_W-1:0] symbol,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic [CNT_W-1:0]        window_length,
    output logic [CNT_W-1:0]        start_position,
    output logic                    overflow
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  text_count_reg, text_count_next;
    logic [PCNT_W-1:0] pat_count_reg, pat_count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              rd_v_reg, rd_v_next;
    logic [CNT_W-1:0]  pos1_reg, pos1_next;
    logic              cell_v_reg;
    logic [CNT_W-1:0]  pos2_reg;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic [CNT_W-1:0]  start_reg, start_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  pos_out_reg;
    logic              ovf_out_reg;

    logic              accept;
    logic              text_full;
    logic              pat_full;
    logic              ram_wr;
    logic [TEXT_AW-1:0] rd_addr;
    logic [SYM_W-1:0]  text_sym;
    logic              out_free;
    cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]  span [MAX_PATTERN+1];

    assign in_ready  = (state_reg == S_LOAD);
    assign accept    = in_valid && in_ready;
    assign text_full = (text_count_reg == CNT_W'(MAX_TEXT));
    assign pat_full  = (pat_count_reg == PCNT_W'(MAX_PATTERN));
    assign ram_wr    = accept && !mode && !text_full;
    assign rd_addr   = TEXT_AW'(iss_reg - CNT_W'(1));
    assign out_free  = !out_valid_reg || out_ready;

    assign ctrl.wr    = accept && mode && !pat_full;
    assign ctrl.clear = accept && mode && last;
    assign ctrl.step  = rd_v_reg;

    mws_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (text_count_reg[TEXT_AW-1:0]),
        .wr_data (symbol),
        .rd_addr (rd_addr),
        .rd_data (text_sym)
    );

    assign span[MAX_PATTERN] = '0;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        mws_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sel      (pat_count_reg == PCNT_W'(j)),
            .wr_sym   (symbol),
            .text_sym (text_sym),
            .tail     (pat_count_reg == PCNT_W'(j + 1)),
            .nb_span  (span[j+1]),
            .span     (span[j])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        text_count_next = text_count_reg;
        pat_count_next  = pat_count_reg;
        ovf_next        = ovf_reg;
        iss_next        = iss_reg;
        rd_v_next       = 1'b0;
        pos1_next       = pos1_reg;
        best_next       = best_reg;
        start_next      = start_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (!mode)
                    begin
                        if (text_full)
                            ovf_next = 1'b1;
                        else
                            text_count_next = text_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        if (pat_full)
                            ovf_next = 1'b1;
                        else
                            pat_count_next = pat_count_reg + PCNT_W'(1);
                        if (last)
                        begin
                            iss_next   = text_count_reg;
                            best_next  = '0;
                            start_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (iss_reg != '0)
                begin
                    rd_v_next = 1'b1;
                    pos1_next = iss_reg;
                    iss_next  = iss_reg - CNT_W'(1);
                end
                else if (!rd_v_reg && !cell_v_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    text_count_next = '0;
                    pat_count_next  = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (cell_v_reg && span[0] != '0 && (best_reg == '0 || span[0] <= best_reg))
        begin
            best_next  = span[0];
            start_next = pos2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            text_count_reg <= '0;
            pat_count_reg  <= '0;
            ovf_reg        <= 1'b0;
            iss_reg        <= '0;
            rd_v_reg       <= 1'b0;
            cell_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            text_count_reg <= text_count_next;
            pat_count_reg  <= pat_count_next;
            ovf_reg        <= ovf_next;
            iss_reg        <= iss_next;
            rd_v_reg       <= rd_v_next;
            cell_v_reg     <= rd_v_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos1_reg  <= pos1_next;
        pos2_reg  <= pos1_reg;
        best_reg  <= best_next;
        start_reg <= start_next;
        if (state_reg == S_DONE && out_free)
        begin
            found_reg   <= (best_reg != '0);
            len_reg     <= best_reg;
            pos_out_reg <= start_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign window_length  = len_reg;
    assign start_position = pos_out_reg;
    assign overflow       = ovf_out_reg;

endmodule

// ----- rtl/mws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mws_cell.sv -----
// One pattern cell: holds one pattern symbol and its running window span.
module mws_cell
    import mws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic             sel,
    input  logic [SYM_W-1:0] wr_sym,
    input  logic [SYM_W-1:0] text_sym,
    input  logic             tail,
    input  logic [CNT_W-1:0] nb_span,
    output logic [CNT_W-1:0] span
);

    logic [SYM_W-1:0] pat_reg;
    logic [CNT_W-1:0] span_reg;
    logic [CNT_W-1:0] span_next;
    logic             match;

    assign match = (text_sym == pat_reg);

    always_comb
    begin
        span_next = span_reg;
        if (ctrl.clear)
        begin
            span_next = '0;
        end
        else if (ctrl.step)
        begin
            if (match)
            begin
                if (tail)
                begin
                    span_next = CNT_W'(1);
                end
                else if (nb_span != '0)
                begin
                    span_next = nb_span + CNT_W'(1);
                end
                else
                begin
                    span_next = '0;
                end
            end
            else if (span_reg != '0)
            begin
                span_next = span_reg + CNT_W'(1);
            end
            else
            begin
                span_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr && sel)
        begin
            pat_reg <= wr_sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= '0;
        end
        else
        begin
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

// ----- bench/tb_min_window_subsequence_unit.sv -----
// Testbench for the minimum window subsequence unit: directed and random problems, self-checked.
`timescale 1ns / 100ps

localparam logic MODE_TEXT    = 1'b0;
localparam logic MODE_PATTERN = 1'b1;

typedef struct {
    logic                      found;
    logic [mws_pkg::CNT_W-1:0] window_length;
    logic [mws_pkg::CNT_W-1:0] start_position;
    logic                      overflow;
} window_result_t;

class window_scoreboard;
    logic [mws_pkg::SYM_W-1:0] text_mem[mws_pkg::MAX_TEXT];
    logic [mws_pkg::SYM_W-1:0] pattern_mem[mws_pkg::MAX_PATTERN];
    int unsigned               text_len;
    int unsigned               pattern_len;
    bit                        words_lost;
    window_result_t            expected_windows[$];
    int                        words;
    int                        searches;
    int                        checked;
    int                        hits;
    int                        overflowed;
    int                        errors;

    function window_result_t shortest_window();
        int unsigned    span[mws_pkg::MAX_PATTERN];
        int unsigned    best;
        int unsigned    first;
        int unsigned    nv;
        int             i;
        int             j;
        window_result_t res;
        best  = 0;
        first = 0;
        foreach (span[k])
            span[k] = 0;
        for (i = int'(text_len) - 1; i >= 0; i--)
        begin
            for (j = 0; j < int'(pattern_len); j++)
            begin
                nv = 0;
                if (text_mem[i] == pattern_mem[j])
                begin
                    if (j == int'(pattern_len) - 1)
                        nv = 1;
                    else if (span[j+1] != 0)
                        nv = span[j+1] + 1;
                end
                else if (span[j] != 0)
                begin
                    nv = span[j] + 1;
                end
                span[j] = nv;
            end
            if (span[0] != 0 && (best == 0 || span[0] <= best))
            begin
                best  = span[0];
                first = i + 1;
            end
        end
        res.found          = (best != 0);
        res.window_length  = best[mws_pkg::CNT_W-1:0];
        res.start_position = first[mws_pkg::CNT_W-1:0];
        res.overflow       = words_lost;
        return res;
    endfunction

    function void note_word(logic m, logic [mws_pkg::SYM_W-1:0] s, logic l);
        window_result_t res;
        words++;
        if (m == MODE_TEXT)
        begin
            if (text_len < mws_pkg::MAX_TEXT)
                text_mem[text_len++] = s;
            else
                words_lost = 1'b1;
        end
        else
        begin
            if (pattern_len < mws_pkg::MAX_PATTERN)
                pattern_mem[pattern_len++] = s;
            else
                words_lost = 1'b1;
            if (l)
            begin
                res = shortest_window();
                expected_windows.push_back(res);
                searches++;
                hits       += res.found;
                overflowed += res.overflow;
                text_len    = 0;
                pattern_len = 0;
                words_lost  = 1'b0;
            end
        end
    endfunction

    function void check_window(logic f, logic [mws_pkg::CNT_W-1:0] wl,
                               logic [mws_pkg::CNT_W-1:0] sp, logic ov);
        window_result_t want;
        checked++;
        if (expected_windows.size() == 0)
        begin
            $error("result with no search pending: found=%0d length=%0d start=%0d overflow=%0d",
                   f, wl, sp, ov);
            errors++;
        end
        else
        begin
            want = expected_windows.pop_front();
            if (f !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, f);
                errors++;
            end
            if (wl !== want.window_length)
            begin
                $error("window_length: expected %0d, actual %0d", want.window_length, wl);
                errors++;
            end
            if (sp !== want.start_position)
            begin
                $error("start_position: expected %0d, actual %0d", want.start_position, sp);
                errors++;
            end
            if (ov !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, ov);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_windows.size();
    endfunction
endclass

module tb_min_window_subsequence_unit;
    import mws_pkg::*;

    localparam int RANDOM_WORDS = 260;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_TEXT + 80;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    mode;
    logic signed [SYM_W-1:0] symbol;
    logic                    last;
    logic                    out_valid;
    logic                    out_ready;
    logic                    found;
    logic [CNT_W-1:0]        window_length;
    logic [CNT_W-1:0]        start_position;
    logic                    overflow;

    window_scoreboard sb;
    int               send_idle;
    int               recv_idle;
    int               random_words;

    min_window_subsequence_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .symbol         (symbol),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .window_length  (window_length),
        .start_position (start_position),
        .overflow       (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_word(mode, symbol, last);
        if (rst_n && out_valid && out_ready)
            sb.check_window(found, window_length, start_position, overflow);
    end

    task automatic send_word(input logic m, input logic [SYM_W-1:0] s, input logic l);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        symbol   <= s;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic random_problem();
        int                 ntext;
        int                 npat;
        int                 alpha;
        int                 k;
        logic [SYM_W-1:0]   base;
        base = $urandom();
        if ($urandom_range(15) == 0)
        begin
            ntext = $urandom_range(100, 300);
            npat  = $urandom_range(8, MAX_PATTERN);
            alpha = 2;
        end
        else
        begin
            ntext = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
            npat  = $urandom_range(1, 6);
            alpha = ($urandom_range(11) == 0) ? 1 << 20 : $urandom_range(1, 5);
        end
        for (k = 0; k < ntext; k++)
        begin
            send_word(MODE_TEXT, base + $urandom_range(alpha - 1), $urandom_range(7) == 0);
            random_words++;
        end
        for (k = 0; k < npat; k++)
        begin
            if ($urandom_range(15) == 0)
            begin
                send_word(MODE_TEXT, base + $urandom_range(alpha - 1), 1'($urandom_range(1)));
                random_words++;
            end
            send_word(MODE_PATTERN, base + $urandom_range(alpha - 1), k == npat - 1);
            random_words++;
        end
    endtask

    task automatic pattern_overflow_problem();
        logic [SYM_W-1:0] x;
        int               k;
        x = $urandom();
        for (k = 0; k < 70; k++)
            send_word(MODE_TEXT, x, 1'b0);
        for (k = 0; k < MAX_PATTERN + 2; k++)
            send_word(MODE_PATTERN, x, k == MAX_PATTERN + 1);
    endtask

    task automatic text_overflow_problem();
        logic [SYM_W-1:0] a;
        int               k;
        a = $urandom();
        send_word(MODE_TEXT, a, 1'b0);
        for (k = 1; k < MAX_TEXT - 1; k++)
            send_word(MODE_TEXT, a + 2 + $urandom_range(1), 1'b0);
        send_word(MODE_TEXT, a + 1, 1'b0);
        for (k = 0; k < 6; k++)
            send_word(MODE_TEXT, a + $urandom_range(1), 1'b0);
        send_word(MODE_PATTERN, a, 1'b0);
        send_word(MODE_PATTERN, a + 1, 1'b1);
    endtask

    initial
    begin
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sb.checked >= 2)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        int phase;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_TEXT;
        symbol       = '0;
        last         = 1'b0;
        send_idle    = 17;
        recv_idle    = 53;
        random_words = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(MODE_PATTERN, 32'h7FFF_FFFF, 1'b1);

        send_word(MODE_TEXT, 32'h8000_0000, 1'b0);
        send_word(MODE_TEXT, 32'h7FFF_FFFF, 1'b1);
        send_word(MODE_TEXT, 32'h0000_0000, 1'b0);
        send_word(MODE_TEXT, 32'hFFFF_FFFF, 1'b0);
        send_word(MODE_TEXT, 32'h8000_0000, 1'b0);
        send_word(MODE_TEXT, 32'hFFFF_FFFF, 1'b0);
        send_word(MODE_PATTERN, 32'h8000_0000, 1'b0);
        send_word(MODE_PATTERN, 32'hFFFF_FFFF, 1'b1);

        send_word(MODE_TEXT, 32'd1, 1'b0);
        send_word(MODE_TEXT, 32'd2, 1'b0);
        send_word(MODE_TEXT, 32'd9, 1'b0);
        send_word(MODE_TEXT, 32'd1, 1'b0);
        send_word(MODE_TEXT, 32'd2, 1'b0);
        send_word(MODE_PATTERN, 32'd1, 1'b0);
        send_word(MODE_TEXT, 32'd7, 1'b0);
        send_word(MODE_PATTERN, 32'd2, 1'b1);

        send_word(MODE_TEXT, 32'd3, 1'b0);
        send_word(MODE_TEXT, 32'd3, 1'b0);
        send_word(MODE_PATTERN, 32'd4, 1'b0);
        send_word(MODE_PATTERN, 32'd3, 1'b1);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 17 : (phase == 1) ? 53 : 0;
            recv_idle = (phase == 0) ? 53 : (phase == 1) ? 17 : 0;
            if (phase == 0)
                pattern_overflow_problem();
            if (phase == 1)
                text_overflow_problem();
            while (random_words < (phase + 1) * RANDOM_WORDS / 3)
                random_problem();
        end
        in_valid <= 1'b0;
        last     <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words forming %0d searches; %0d windows found, %0d with overflow.",
                 sb.words, sb.searches, sb.hits, sb.overflowed);
        $display("Both sides idled in turn, the output was held off for %0d cycles once.",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- min_window_subsequence_unit.f -----
rtl/mws_pkg.sv
rtl/mws_ram.sv
rtl/mws_cell.sv
rtl/min_window_subsequence_unit.sv
bench/tb_min_window_subsequence_unit.sv
